// ----- rtl/bba_pkg.sv -----
package bba_pkg;

   localparam int NUM_BLOCKS = 256;
   localparam int WORD_BITS  = 32;
   localparam int MAX_RUN    = 64;
   localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

   localparam int REQ_W   = 16;                      // request_bytes
   localparam int IDX_W   = 8;                       // block_index / granted_index
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 9;                       // free_count field
   localparam int SHIFT_W = 4;
   localparam int SUM_W   = REQ_W + 1;               // bytes + rounding term
   localparam int FREE_W  = $clog2(NUM_BLOCKS + 1);  // internal free counter
   localparam int RUN_W   = $clog2(MAX_RUN + 1);
   localparam int BIT_W   = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int WIDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_SPACE = 2'd1,
      STAT_BAD_SIZE = 2'd2,
      STAT_BAD_FREE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FREE
   } state_type;

   // bits past the end of the pool stay zero so the finder never picks them
   function automatic logic [WORD_BITS-1:0] reset_word(input int w);
      logic [WORD_BITS-1:0] word;
      word = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         word[b] = ((w * WORD_BITS + b) < NUM_BLOCKS);
      end
      return word;
   endfunction

endpackage

// ----- rtl/bba_chan_if.sv -----
interface bba_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [bba_pkg::REQ_W-1:0]  request_bytes;
   logic [bba_pkg::IDX_W-1:0]  block_index;
   logic                       free_last;

   modport source (output valid, opcode, request_bytes, block_index, free_last,
                   input ready);
   modport sink   (input valid, opcode, request_bytes, block_index, free_last,
                   output ready);
endinterface

interface bba_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::IDX_W-1:0]  granted_index;
   logic [bba_pkg::STAT_W-1:0] status;
   logic                       last;
   logic [bba_pkg::CNT_W-1:0]  free_count;

   modport source (output valid, granted_index, status, last, free_count,
                   input ready);
   modport sink   (input valid, granted_index, status, last, free_count,
                   output ready);
endinterface

// ----- rtl/bitmap_block_allocator_top.sv -----
// Bitmap block allocator: a pool of NUM_BLOCKS blocks tracked by a free bitmap
// (1 = free, all free after reset) and a free counter. An allocate word asks
// for request_bytes; the block count is ceil(bytes / 2^block_shift). A count of
// zero or above MAX_RUN gives one bad-size result, a count above the free
// counter gives one out-of-space result, and otherwise the lowest free blocks
// are granted in ascending order, one result word per block, last set on the
// final one. A free word returns one block and echoes it in a single result;
// an out-of-range or already free index gives bad-free status and no change.
// Timing: one lowest-free finder scans one bitmap word per cycle and grants at
// most one block per cycle. An allocate passes over each bitmap word that has
// no free bit left (at most MAP_WORDS - 1 of them) and grants from the first
// word with one. req_ch accepts only in idle, so a new request is taken only
// after the last result of the previous one is loaded; back-pressure on
// rsp_ch stalls the check, each grant and the free. The bitmap is flops
// loaded with all ones by reset, so no clearing pass is needed. block_shift
// (reset 5) is written through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle, and the block itself does not enforce this.
module bitmap_block_allocator_top (
   input  logic                         clock,
   input  logic                         reset,
   bba_req_if.sink                      req_ch,
   bba_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [bba_pkg::SHIFT_W-1:0]  csr_wr_data
);

   // ---------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------
   bba_pkg::state_type               state_ff, state_in;
   logic [bba_pkg::WORD_BITS-1:0]    map_ff [bba_pkg::MAP_WORDS];
   logic [bba_pkg::FREE_W-1:0]       free_ff, free_in;
   logic [bba_pkg::SHIFT_W-1:0]      shift_ff;

   // latched request
   logic [bba_pkg::REQ_W-1:0]        bytes_ff;
   logic [bba_pkg::IDX_W-1:0]        idx_ff;

   // allocation run
   logic [bba_pkg::RUN_W-1:0]        need_ff, need_in;
   logic [bba_pkg::RUN_W-1:0]        got_ff, got_in;
   logic [bba_pkg::WIDX_W-1:0]       word_ff, word_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic [bba_pkg::STAT_W-1:0]       rsp_stat_ff, rsp_stat_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic [bba_pkg::CNT_W-1:0]        rsp_cnt_ff, rsp_cnt_in;

   // bitmap write port
   logic                             map_we;
   logic [bba_pkg::WIDX_W-1:0]       map_waddr;
   logic [bba_pkg::WORD_BITS-1:0]    map_wdata;

   // ---------------------------------------------------------------------
   // datapath helpers
   // ---------------------------------------------------------------------
   logic                             slot_ok;   // output register can load
   logic                             accept;
   logic [bba_pkg::SUM_W-1:0]        round_term, size_sum, need_full;
   logic [bba_pkg::WORD_BITS-1:0]    scan_word;
   logic                             scan_found;
   logic [bba_pkg::BIT_W-1:0]        scan_bit;
   logic                             free_in_range;
   logic [bba_pkg::WIDX_W-1:0]       free_widx;
   logic [bba_pkg::BIT_W-1:0]        free_bit;
   logic [bba_pkg::WORD_BITS-1:0]    free_word;
   logic                             grant_last;

   assign slot_ok = !rsp_valid_ff || rsp_ch.ready;
   assign accept  = req_ch.valid && req_ch.ready;

   // need = ceil(bytes / 2^shift)
   assign round_term = (bba_pkg::SUM_W'(1) << shift_ff) - bba_pkg::SUM_W'(1);
   assign size_sum   = {1'b0, bytes_ff} + round_term;
   assign need_full  = size_sum >> shift_ff;

   // one word of the bitmap goes through the finder each cycle
   assign scan_word = map_ff[word_ff];

   bba_find u_find (
      .word    (scan_word),
      .found   (scan_found),
      .bit_pos (scan_bit)
   );

   assign free_in_range = (int'(idx_ff) < bba_pkg::NUM_BLOCKS);
   assign free_widx     = bba_pkg::WIDX_W'(int'(idx_ff) / bba_pkg::WORD_BITS);
   assign free_bit      = bba_pkg::BIT_W'(int'(idx_ff) % bba_pkg::WORD_BITS);
   assign free_word     = free_in_range ? map_ff[free_widx] : '0;

   assign grant_last = (bba_pkg::RUN_W'(got_ff + bba_pkg::RUN_W'(1)) == need_ff);

   assign req_ch.ready = (state_ff == bba_pkg::S_IDLE);

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      need_in      = need_ff;
      got_in       = got_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      map_we       = 1'b0;
      map_waddr    = word_ff;
      map_wdata    = scan_word;

      case (state_ff)
         bba_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (req_ch.opcode == bba_pkg::OP_FREE) ? bba_pkg::S_FREE
                                                              : bba_pkg::S_CHECK;
            end
         end

         bba_pkg::S_CHECK: begin
            if (slot_ok) begin
               if (need_full == '0 ||
                   need_full > bba_pkg::SUM_W'(bba_pkg::MAX_RUN)) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_stat_in  = bba_pkg::STAT_BAD_SIZE;
                  rsp_last_in  = 1'b1;
                  rsp_cnt_in   = bba_pkg::CNT_W'(free_ff);
                  state_in     = bba_pkg::S_IDLE;
               end else if (need_full > bba_pkg::SUM_W'(free_ff)) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = '0;
                  rsp_stat_in  = bba_pkg::STAT_NO_SPACE;
                  rsp_last_in  = 1'b1;
                  rsp_cnt_in   = bba_pkg::CNT_W'(free_ff);
                  state_in     = bba_pkg::S_IDLE;
               end else begin
                  need_in  = bba_pkg::RUN_W'(need_full);
                  got_in   = '0;
                  word_in  = '0;
                  state_in = bba_pkg::S_SCAN;
               end
            end
         end

         bba_pkg::S_SCAN: begin
            if (!scan_found) begin
               word_in = bba_pkg::WIDX_W'(word_ff + bba_pkg::WIDX_W'(1));
            end else if (slot_ok) begin
               map_we              = 1'b1;
               map_wdata[scan_bit] = 1'b0;
               free_in             = bba_pkg::FREE_W'(free_ff - bba_pkg::FREE_W'(1));
               got_in              = bba_pkg::RUN_W'(got_ff + bba_pkg::RUN_W'(1));
               rsp_valid_in        = 1'b1;
               rsp_idx_in          = bba_pkg::IDX_W'(int'(word_ff) * bba_pkg::WORD_BITS
                                                     + int'(scan_bit));
               rsp_stat_in         = bba_pkg::STAT_OK;
               rsp_last_in         = grant_last;
               rsp_cnt_in          = bba_pkg::CNT_W'(free_in);
               if (grant_last) begin
                  state_in = bba_pkg::S_IDLE;
               end
            end
         end

         bba_pkg::S_FREE: begin
            if (slot_ok) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_last_in  = 1'b1;
               state_in     = bba_pkg::S_IDLE;
               if (!free_in_range || free_word[free_bit]) begin
                  rsp_stat_in = bba_pkg::STAT_BAD_FREE;
               end else begin
                  map_we              = 1'b1;
                  map_waddr           = free_widx;
                  map_wdata           = free_word;
                  map_wdata[free_bit] = 1'b1;
                  free_in             = bba_pkg::FREE_W'(free_ff + bba_pkg::FREE_W'(1));
                  rsp_stat_in         = bba_pkg::STAT_OK;
               end
               rsp_cnt_in = bba_pkg::CNT_W'(free_in);
            end
         end

         default: begin
            state_in = bba_pkg::S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_IDLE;
         free_ff      <= bba_pkg::FREE_W'(bba_pkg::NUM_BLOCKS);
         shift_ff     <= bba_pkg::SHIFT_W'(5);
         rsp_valid_ff <= 1'b0;
         for (int w = 0; w < bba_pkg::MAP_WORDS; w++) begin
            map_ff[w] <= bba_pkg::reset_word(w);
         end
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
         if (map_we) begin
            map_ff[map_waddr] <= map_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= req_ch.request_bytes;
         idx_ff   <= req_ch.block_index;
      end
      need_ff    <= need_in;
      got_ff     <= got_in;
      word_ff    <= word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.granted_index = rsp_idx_ff;
   assign rsp_ch.status        = rsp_stat_ff;
   assign rsp_ch.last          = rsp_last_ff;
   assign rsp_ch.free_count    = rsp_cnt_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      int'(free_ff) <= bba_pkg::NUM_BLOCKS)
      else $error("free counter above pool size");

   a_run_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::S_SCAN |-> got_ff < need_ff && free_ff != '0)
      else $error("scan running with nothing left to grant");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status != bba_pkg::STAT_OK |-> rsp_ch.last)
      else $error("error result not marked last");

   a_scan_in_map: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::S_SCAN |-> int'(word_ff) < bba_pkg::MAP_WORDS)
      else $error("scan ran past the bitmap");
`endif

endmodule

// ----- rtl/bba_find.sv -----
// lowest set bit of one bitmap word
module bba_find (
   input  logic [bba_pkg::WORD_BITS-1:0] word,
   output logic                          found,
   output logic [bba_pkg::BIT_W-1:0]     bit_pos
);

   always_comb begin
      found   = |word;
      bit_pos = '0;
      for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (word[i]) begin
            bit_pos = bba_pkg::BIT_W'(i);
         end
      end
   end

endmodule
